// ===== hw/rtl/dcrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrs_pkg: shared types and constants for the direct command retry sender
// Word formats, command/echo/result codes and the frame byte selector.
// ----------------------------------------------------------------------------
package dcrs_pkg;

    // Input word.
    typedef struct packed {
        logic [1:0] command;
        logic [7:0] cmd_one;
        logic [7:0] cmd_two;
        logic [1:0] echo_code;
    } t_in_word;

    // Result word.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] frame_byte;
        logic       last;
        logic [7:0] sent_cmd_one;
        logic [7:0] recv_cmd_one;
        logic [7:0] recv_cmd_two;
        logic       device_disabled;
    } t_out_word;

    // One job handed from the command logic to the emitter.
    // Frame: b1/b2 are the command bytes. Ack report: b1 sent, b2/b3 received.
    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic       disabled;
    } t_job;

    // Command codes
    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ECHO = 2'd1;
    localparam logic [1:0] CMD_ACK  = 2'd2;
    localparam logic [1:0] CMD_TICK = 2'd3;

    // Echo codes
    localparam logic [1:0] ECHO_ACK = 2'd0;

    // Result kinds
    localparam logic [2:0] KIND_FRAME   = 3'd0;
    localparam logic [2:0] KIND_ACK     = 3'd1;
    localparam logic [2:0] KIND_WAIT    = 3'd2;
    localparam logic [2:0] KIND_ECHOERR = 3'd3;
    localparam logic [2:0] KIND_BUSY    = 3'd4;
    localparam logic [2:0] KIND_GAVEUP  = 3'd5;

    // Register indexes
    localparam logic [1:0] REG_ADDR = 2'd0;
    localparam logic [1:0] REG_HOPS = 2'd1;
    localparam logic [1:0] REG_WAIT = 2'd2;

    localparam logic [7:0]  FRAME_START  = 8'h62;
    localparam logic [15:0] DEFAULT_WAIT = 16'd4583;
    localparam logic [1:0]  ACK_LIMIT    = 2'd3;
    localparam logic [2:0]  FRAME_LAST   = 3'd6;

    // Byte idx of the standard frame.
    function automatic logic [7:0] frame_byte(
        input logic [2:0]  idx,
        input logic [23:0] addr,
        input logic [1:0]  hops_cfg,
        input logic [7:0]  first,
        input logic [7:0]  second
    );
        logic [1:0] hops;
        logic [7:0] b;
        hops = (hops_cfg == 2'd0) ? 2'd3 : hops_cfg;
        case (idx)
            3'd0: b = FRAME_START;
            3'd1: b = addr[23:16];
            3'd2: b = addr[15:8];
            3'd3: b = addr[7:0];
            3'd4: b = {4'd0, hops, hops};
            3'd5: b = first;
            3'd6: b = second;
            default: b = 8'd0;
        endcase
        return b;
    endfunction

endpackage

// ===== hw/rtl/direct_command_retry_sender.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_command_retry_sender: direct command sender with ack retries
// Sends one command frame at a time, tracks echo/ack and retries on timeout.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_in_valid / o_in_stall / i_in_word) carries event words:
//   send request, modem echo status, acknowledgement received, timer tick.
//   Output channel (o_out_valid / i_out_stall / o_out_word) carries result
//   words: frame bytes, ack report, waiting, echo failed, busy, gave up.
//   The last word caused by one input word has last set.
//   Config port: i_cfg_we with i_cfg_idx (0 address, 1 hops, 2 wait ticks)
//   and i_cfg_data; write only while idle.
// Timing
//   State updates in the cycle the input word is accepted; the job lands in
//   a one-entry job register, then moves into the emitter, where the first
//   result word shows. A frame is seven bytes, one byte per cycle while the
//   output is not stalled; any other result is a single word, and an input
//   that causes no result only updates state. Throughput is set by the
//   emitter; the job register takes the next word while the emitter is busy.
// Reset / stall
//   Synchronous active-low reset clears pending state, timer, retry limit,
//   disabled flag and loads register defaults (wait 4583 ticks).
//   An output stall holds the current word; input keeps flowing until the
//   job register is full, then o_in_stall rises.
// ----------------------------------------------------------------------------
module direct_command_retry_sender (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // config port
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_idx,
    input  logic [23:0]         i_cfg_data,
    // input channel
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  dcrs_pkg::t_in_word  i_in_word,
    // output channel
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output dcrs_pkg::t_out_word o_out_word
);

    // config registers
    logic [23:0] r_addr;
    logic [1:0]  r_hops;
    logic [15:0] r_wait_ticks;

    // command state
    logic        r_pending_valid, n_pending_valid;
    logic [7:0]  r_pending_first, n_pending_first;
    logic [7:0]  r_pending_second, n_pending_second;
    logic [2:0]  r_retry_count, n_retry_count;
    logic [1:0]  r_retry_limit, n_retry_limit;
    logic [15:0] r_wait_timer, n_wait_timer;
    logic        r_timer_running, n_timer_running;
    logic        r_disabled_flag, n_disabled_flag;

    // job slot between command logic and emitter
    logic           r_job_valid;
    dcrs_pkg::t_job r_job;
    dcrs_pkg::t_job n_job;
    logic           n_job_gen;
    logic           job_take;
    logic           in_acc;
    logic [2:0]     retry_next;

    assign o_in_stall = r_job_valid && !job_take;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign retry_next = r_retry_count + 3'd1;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr       <= 24'd0;
            r_hops       <= 2'd0;
            r_wait_ticks <= dcrs_pkg::DEFAULT_WAIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                dcrs_pkg::REG_ADDR: r_addr       <= i_cfg_data;
                dcrs_pkg::REG_HOPS: r_hops       <= i_cfg_data[1:0];
                dcrs_pkg::REG_WAIT: r_wait_ticks <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // per-event state update and job build
    always_comb begin
        n_pending_valid  = r_pending_valid;
        n_pending_first  = r_pending_first;
        n_pending_second = r_pending_second;
        n_retry_count    = r_retry_count;
        n_retry_limit    = r_retry_limit;
        n_wait_timer     = r_wait_timer;
        n_timer_running  = r_timer_running;
        n_disabled_flag  = r_disabled_flag;
        n_job_gen        = 1'b0;
        n_job            = '0;

        case (i_in_word.command)
            dcrs_pkg::CMD_SEND: begin
                n_job_gen = 1'b1;
                if (r_pending_valid) begin
                    n_job.kind = dcrs_pkg::KIND_BUSY;
                end else begin
                    n_pending_valid  = 1'b1;
                    n_pending_first  = i_in_word.cmd_one;
                    n_pending_second = i_in_word.cmd_two;
                    n_retry_count    = 3'd0;
                    n_job.kind       = dcrs_pkg::KIND_FRAME;
                    n_job.b1         = i_in_word.cmd_one;
                    n_job.b2         = i_in_word.cmd_two;
                end
            end
            dcrs_pkg::CMD_ECHO: begin
                if (r_pending_valid) begin
                    n_job_gen = 1'b1;
                    if (i_in_word.echo_code == dcrs_pkg::ECHO_ACK) begin
                        // zero ticks acts as one
                        n_wait_timer    = (r_wait_ticks == 16'd0) ? 16'd1 : r_wait_ticks;
                        n_timer_running = 1'b1;
                        n_job.kind      = dcrs_pkg::KIND_WAIT;
                    end else begin
                        n_pending_valid = 1'b0;
                        n_timer_running = 1'b0;
                        n_wait_timer    = 16'd0;
                        n_job.kind      = dcrs_pkg::KIND_ECHOERR;
                    end
                end
            end
            dcrs_pkg::CMD_ACK: begin
                if (r_pending_valid) begin
                    n_job_gen       = 1'b1;
                    n_retry_limit   = dcrs_pkg::ACK_LIMIT;
                    n_pending_valid = 1'b0;
                    n_timer_running = 1'b0;
                    n_wait_timer    = 16'd0;
                    n_job.kind      = dcrs_pkg::KIND_ACK;
                    n_job.b1        = r_pending_first;
                    n_job.b2        = i_in_word.cmd_one;
                    n_job.b3        = i_in_word.cmd_two;
                end
            end
            dcrs_pkg::CMD_TICK: begin
                if (r_timer_running) begin
                    if (r_wait_timer > 16'd1) begin
                        n_wait_timer = r_wait_timer - 16'd1;
                    end else begin
                        // expiry: resend or give up
                        n_timer_running = 1'b0;
                        n_wait_timer    = 16'd0;
                        if (r_pending_valid) begin
                            n_job_gen     = 1'b1;
                            n_retry_count = retry_next;
                            if (retry_next <= {1'b0, r_retry_limit}) begin
                                n_job.kind = dcrs_pkg::KIND_FRAME;
                                n_job.b1   = r_pending_first;
                                n_job.b2   = r_pending_second;
                            end else begin
                                n_retry_limit   = (r_retry_limit > 2'd1) ?
                                                  (r_retry_limit - 2'd1) : 2'd0;
                                n_disabled_flag = 1'b1;
                                n_pending_valid = 1'b0;
                                n_job.kind      = dcrs_pkg::KIND_GAVEUP;
                            end
                        end
                    end
                end
            end
            default: ;
        endcase
        // flag as it stands after this event
        n_job.disabled = n_disabled_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending_valid <= 1'b0;
            r_retry_count   <= 3'd0;
            r_retry_limit   <= 2'd0;
            r_wait_timer    <= 16'd0;
            r_timer_running <= 1'b0;
            r_disabled_flag <= 1'b0;
            r_job_valid     <= 1'b0;
        end else begin
            if (in_acc) begin
                r_pending_valid <= n_pending_valid;
                r_retry_count   <= n_retry_count;
                r_retry_limit   <= n_retry_limit;
                r_wait_timer    <= n_wait_timer;
                r_timer_running <= n_timer_running;
                r_disabled_flag <= n_disabled_flag;
            end
            if (in_acc && n_job_gen) begin
                r_job_valid <= 1'b1;
            end else if (job_take) begin
                r_job_valid <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_pending_first  <= n_pending_first;
            r_pending_second <= n_pending_second;
        end
        if (in_acc && n_job_gen) begin
            r_job <= n_job;
        end
    end

    dcrs_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (r_job_valid),
        .i_job       (r_job),
        .o_job_take  (job_take),
        .i_addr      (r_addr),
        .i_hops      (r_hops),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

    // Timer only runs for a pending command.
    a_timer_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_running |-> r_pending_valid)
        else $error("timer running with nothing pending");

    // A running timer never sits at zero.
    a_timer_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_running |-> (r_wait_timer != 16'd0))
        else $error("running timer at zero");

    // Disabled flag is sticky.
    a_disabled_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_disabled_flag |=> r_disabled_flag)
        else $error("disabled flag cleared");

    // Retries stop one past the highest limit.
    a_retry_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_retry_count <= 3'd4)
        else $error("retry count out of range");

endmodule

// ===== hw/rtl/dcrs_emit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dcrs_emit: result word emitter
// Holds one job and plays it out: seven frame bytes or a single report word.
// ----------------------------------------------------------------------------
module dcrs_emit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  dcrs_pkg::t_job     i_job,
    output logic               o_job_take,
    input  logic [23:0]        i_addr,
    input  logic [1:0]         i_hops,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output dcrs_pkg::t_out_word o_out_word
);

    logic           r_valid;
    dcrs_pkg::t_job r_job;
    logic [2:0]     r_idx;

    logic is_frame;
    logic is_last;
    logic done;
    logic beat;

    assign is_frame   = (r_job.kind == dcrs_pkg::KIND_FRAME);
    assign is_last    = !is_frame || (r_idx == dcrs_pkg::FRAME_LAST);
    assign beat       = r_valid && !i_out_stall;
    assign done       = beat && is_last;
    assign o_job_take = i_job_valid && (!r_valid || done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (o_job_take) begin
            r_valid <= 1'b1;
            r_idx   <= 3'd0;
        end else if (done) begin
            r_valid <= 1'b0;
            r_idx   <= 3'd0;
        end else if (beat) begin
            r_idx   <= r_idx + 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_take) begin
            r_job <= i_job;
        end
    end

    assign o_out_valid = r_valid;

    always_comb begin
        o_out_word                 = '0;
        o_out_word.kind            = r_job.kind;
        o_out_word.last            = is_last;
        o_out_word.device_disabled = r_job.disabled;
        if (is_frame) begin
            o_out_word.frame_byte = dcrs_pkg::frame_byte(r_idx, i_addr, i_hops,
                                                         r_job.b1, r_job.b2);
        end
        if (r_job.kind == dcrs_pkg::KIND_ACK) begin
            o_out_word.sent_cmd_one = r_job.b1;
            o_out_word.recv_cmd_one = r_job.b2;
            o_out_word.recv_cmd_two = r_job.b3;
        end
    end

    // Byte index never runs past the frame end.
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> (r_idx <= dcrs_pkg::FRAME_LAST))
        else $error("emitter index past frame end");

    // A single-word job is never part way through.
    a_single_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !is_frame) |-> (r_idx == 3'd0))
        else $error("single result with nonzero index");

endmodule
